// ===== design/lsvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsvm_pkg
// Shared widths, command and register codes, and controller/datapath structs
// for the linear-kernel SVM scorer.
// ----------------------------------------------------------------------------
package lsvm_pkg;

   localparam int DEF_MAX_VECTORS = 64;
   localparam int DEF_MAX_DIM     = 64;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 6;
   localparam int DATA_W     = 16;
   localparam int ALPHA_W    = 16;
   localparam int DOT_W      = 40;
   localparam int PROD_W     = 32;
   localparam int BIAS_W     = 32;
   localparam int COUNT_W    = 7;
   localparam int SCORE_W    = 48;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD_VECTOR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY       = 2'd2;

   localparam logic [1:0] REG_BIAS        = 2'd0;
   localparam logic [1:0] REG_NUM_VECTORS = 2'd1;
   localparam logic [1:0] REG_FEATURE_DIM = 2'd2;

   localparam logic [COUNT_W-1:0] FEATURE_DIM_RESET = 7'd1;

   typedef struct packed {
      logic load_vector;
      logic load_weight;
      logic query_start;
      logic mac_issue;
      logic score_issue;
      logic live;
      logic acc_init;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic out_free;
   } dp_status_type;

endpackage

// ===== design/linear_svm_predict.sv =====
// load items: taken back to back while no query is in progress
// query element: one single multiply-accumulate pass over the dot-product memory,
//   covering the nv support vectors in use
// last element of a query adds the weighted-sum pass and the result hand-off,
//   which waits while the previous result has not yet been taken
// reset clears control registers and counters; stores keep their contents
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_svm_predict
// Linear-kernel SVM scorer: register port, controller and datapath.
// ----------------------------------------------------------------------------
module linear_svm_predict #(
   parameter int MAX_VECTORS = lsvm_pkg::DEF_MAX_VECTORS,
   parameter int MAX_DIM     = lsvm_pkg::DEF_MAX_DIM
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lsvm_pkg::CMD_W-1:0]           req_command,
   input  logic [lsvm_pkg::INDEX_W-1:0]         req_vector_index,
   input  logic [lsvm_pkg::INDEX_W-1:0]         req_element_index,
   input  logic signed [lsvm_pkg::DATA_W-1:0]   req_value,
   input  logic [lsvm_pkg::ALPHA_W-1:0]         req_alpha,
   input  logic                                 req_label_negative,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lsvm_pkg::SCORE_W-1:0]  rsp_score,
   output logic                                 rsp_saturated,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lsvm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [lsvm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [lsvm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   import lsvm_pkg::*;

   localparam int VIW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
   localparam int PW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int NVW = $clog2(MAX_VECTORS + 1);
   localparam int DW  = $clog2(MAX_DIM + 1);

   // register port
   logic signed [BIAS_W-1:0] bias_ff;
   logic [COUNT_W-1:0]       num_vectors_ff;
   logic [COUNT_W-1:0]       feature_dim_ff;
   logic                     csr_write;
   logic [1:0]               reg_sel;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff        <= '0;
         num_vectors_ff <= '0;
         feature_dim_ff <= FEATURE_DIM_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_BIAS:        bias_ff        <= $signed(pwdata);
            REG_NUM_VECTORS: num_vectors_ff <= pwdata[COUNT_W-1:0];
            REG_FEATURE_DIM: feature_dim_ff <= pwdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_BIAS:        prdata = bias_ff;
         REG_NUM_VECTORS: prdata = CSR_DATA_W'(num_vectors_ff);
         REG_FEATURE_DIM: prdata = CSR_DATA_W'(feature_dim_ff);
         default:         prdata = '0;
      endcase
   end

   // effective sizes
   logic [NVW-1:0] nv;
   logic [DW-1:0]  dim;

   assign nv = (32'(num_vectors_ff) > 32'(MAX_VECTORS)) ? NVW'(MAX_VECTORS)
                                                        : NVW'(num_vectors_ff);

   always_comb begin
      if (feature_dim_ff == '0) begin
         dim = DW'(1);
      end else if (32'(feature_dim_ff) > 32'(MAX_DIM)) begin
         dim = DW'(MAX_DIM);
      end else begin
         dim = DW'(feature_dim_ff);
      end
   end

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic [VIW-1:0] idx;
   logic [PW-1:0]  pos;

   lsvm_ctrl #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .nv          (nv),
      .dim         (dim),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .idx         (idx),
      .pos         (pos)
   );

   lsvm_datapath #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .idx            (idx),
      .pos            (pos),
      .vector_index   (req_vector_index),
      .element_index  (req_element_index),
      .value          (req_value),
      .alpha          (req_alpha),
      .label_negative (req_label_negative),
      .bias           (bias_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_score      (rsp_score),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

// ===== design/lsvm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsvm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lsvm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsvm_datapath
// Vector, weight and dot-product memories, the shared multiply-accumulate
// pipe, the weighted-sum accumulator and the result register.
// ----------------------------------------------------------------------------
module lsvm_datapath #(
   parameter int MAX_VECTORS = lsvm_pkg::DEF_MAX_VECTORS,
   parameter int MAX_DIM     = lsvm_pkg::DEF_MAX_DIM,
   localparam int VIW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1,
   localparam int PW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lsvm_pkg::dp_cmd_type                 cmd,
   output lsvm_pkg::dp_status_type              status,
   input  logic [VIW-1:0]                       idx,
   input  logic [PW-1:0]                        pos,
   input  logic [lsvm_pkg::INDEX_W-1:0]         vector_index,
   input  logic [lsvm_pkg::INDEX_W-1:0]         element_index,
   input  logic signed [lsvm_pkg::DATA_W-1:0]   value,
   input  logic [lsvm_pkg::ALPHA_W-1:0]         alpha,
   input  logic                                 label_negative,
   input  logic signed [lsvm_pkg::BIAS_W-1:0]   bias,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lsvm_pkg::SCORE_W-1:0]  rsp_score,
   output logic                                 rsp_saturated
);

   import lsvm_pkg::*;

   localparam int VDEPTH  = MAX_VECTORS * MAX_DIM;
   localparam int VAW     = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
   localparam int LO_W    = 16;
   localparam int HI_W    = DOT_W - LO_W + ALPHA_W + 1;
   localparam int FULL_W  = HI_W + LO_W;
   localparam int FRAC_SH = 12;
   localparam int TERM_W  = FULL_W - FRAC_SH;
   localparam int ACC_W   = 46 + $clog2(MAX_VECTORS + 1);

   // load path
   logic           vec_wr_en;
   logic           wt_wr_en;
   logic [VAW-1:0] vec_wr_addr;

   assign vec_wr_en = cmd.load_vector && (32'(vector_index) < 32'(MAX_VECTORS))
                      && (32'(element_index) < 32'(MAX_DIM));
   assign wt_wr_en  = cmd.load_weight && (32'(vector_index) < 32'(MAX_VECTORS));
   assign vec_wr_addr = VAW'(32'(vector_index) * 32'(MAX_DIM) + 32'(element_index));

   // query operand and vector address walk
   logic [VAW-1:0]           vaddr_ff;
   logic signed [DATA_W-1:0] feat_ff;

   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         vaddr_ff <= VAW'(pos);
         feat_ff  <= value;
      end else if (cmd.mac_issue) begin
         vaddr_ff <= vaddr_ff + VAW'(MAX_DIM);
      end
   end

   // memories
   logic [DATA_W-1:0]  vec_rd;
   logic [ALPHA_W:0]   wt_rd;
   logic [DOT_W-1:0]   dot_rd;
   logic [DOT_W-1:0]   dot_wr;
   logic               mac_c_ff;
   logic [VIW-1:0]     idx_c_ff;

   lsvm_ram #(.WIDTH(DATA_W), .DEPTH(VDEPTH)) u_vector_ram (
      .clock   (clock),
      .wr_en   (vec_wr_en),
      .wr_addr (vec_wr_addr),
      .wr_data (value),
      .rd_addr (vaddr_ff),
      .rd_data (vec_rd)
   );

   lsvm_ram #(.WIDTH(ALPHA_W + 1), .DEPTH(MAX_VECTORS)) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (VIW'(vector_index)),
      .wr_data ({label_negative, alpha}),
      .rd_addr (idx),
      .rd_data (wt_rd)
   );

   lsvm_ram #(.WIDTH(DOT_W), .DEPTH(MAX_VECTORS)) u_dot_ram (
      .clock   (clock),
      .wr_en   (mac_c_ff),
      .wr_addr (idx_c_ff),
      .wr_data (dot_wr),
      .rd_addr (idx),
      .rd_data (dot_rd)
   );

   // stage b: read data back, multiply
   logic                      mac_b_ff;
   logic                      score_b_ff;
   logic                      live_b_ff;
   logic [VIW-1:0]            idx_b_ff;
   logic signed [DOT_W-1:0]   dot_b;
   logic signed [PROD_W-1:0]  prod_c_in;
   logic signed [HI_W-1:0]    hi_c_in;
   logic [2*LO_W-1:0]         lo_c_in;

   assign dot_b     = live_b_ff ? $signed(dot_rd) : '0;
   assign prod_c_in = $signed(vec_rd) * feat_ff;
   assign hi_c_in   = $signed(dot_b[DOT_W-1:LO_W]) * $signed({1'b0, wt_rd[ALPHA_W-1:0]});
   assign lo_c_in   = dot_b[LO_W-1:0] * wt_rd[ALPHA_W-1:0];

   // stage c: dot update, weighted term
   logic                      score_c_ff;
   logic signed [PROD_W-1:0]  prod_c_ff;
   logic signed [DOT_W-1:0]   dot_c_ff;
   logic signed [HI_W-1:0]    hi_c_ff;
   logic [2*LO_W-1:0]         lo_c_ff;
   logic                      neg_c_ff;
   logic signed [DOT_W:0]     dot_sum;
   logic signed [FULL_W-1:0]  prod_full;

   assign dot_sum = dot_c_ff + prod_c_ff;

   always_comb begin
      if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
         dot_wr = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
      end else begin
         dot_wr = dot_sum[DOT_W-1:0];
      end
   end

   assign prod_full = $signed({hi_c_ff, {LO_W{1'b0}}})
                      + $signed({{(FULL_W-2*LO_W){1'b0}}, lo_c_ff});

   // stage d: accumulate
   logic                      score_d_ff;
   logic                      neg_d_ff;
   logic signed [TERM_W-1:0]  term_d_ff;
   logic signed [ACC_W-1:0]   acc_ff;

   // result
   logic                      rsp_valid_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic                      sat_ff;
   logic [ACC_W-SCORE_W:0]    acc_upper;
   logic                      sat_in;
   logic signed [SCORE_W-1:0] score_in;

   assign acc_upper = acc_ff[ACC_W-1:SCORE_W-1];
   assign sat_in    = !((&acc_upper) || !(|acc_upper));

   always_comb begin
      if (sat_in) begin
         score_in = acc_ff[ACC_W-1] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                    : {1'b0, {(SCORE_W-1){1'b1}}};
      end else begin
         score_in = acc_ff[SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_b_ff     <= 1'b0;
         score_b_ff   <= 1'b0;
         mac_c_ff     <= 1'b0;
         score_c_ff   <= 1'b0;
         score_d_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mac_b_ff   <= cmd.mac_issue;
         score_b_ff <= cmd.score_issue;
         mac_c_ff   <= mac_b_ff;
         score_c_ff <= score_b_ff;
         score_d_ff <= score_c_ff;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      live_b_ff <= cmd.live;
      idx_b_ff  <= idx;
      idx_c_ff  <= idx_b_ff;
      prod_c_ff <= prod_c_in;
      dot_c_ff  <= dot_b;
      hi_c_ff   <= hi_c_in;
      lo_c_ff   <= lo_c_in;
      neg_c_ff  <= wt_rd[ALPHA_W];
      neg_d_ff  <= neg_c_ff;
      term_d_ff <= $signed(prod_full[FULL_W-1:FRAC_SH]);
      if (cmd.acc_init) begin
         acc_ff <= ACC_W'(bias);
      end else if (score_d_ff) begin
         acc_ff <= neg_d_ff ? acc_ff - ACC_W'(term_d_ff) : acc_ff + ACC_W'(term_d_ff);
      end
      if (cmd.out_load) begin
         score_ff <= score_in;
         sat_ff   <= sat_in;
      end
   end

   assign status.busy     = mac_b_ff || mac_c_ff || score_b_ff || score_c_ff || score_d_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_score     = score_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ===== design/lsvm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsvm_ctrl
// Sequencer: item decode, per-element pass over the support vectors, the
// weighted-sum pass and the hand-off to the result register.
// ----------------------------------------------------------------------------
module lsvm_ctrl #(
   parameter int MAX_VECTORS = lsvm_pkg::DEF_MAX_VECTORS,
   parameter int MAX_DIM     = lsvm_pkg::DEF_MAX_DIM,
   localparam int VIW = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1,
   localparam int PW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int NVW = $clog2(MAX_VECTORS + 1),
   localparam int DW  = $clog2(MAX_DIM + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lsvm_pkg::CMD_W-1:0]   req_command,
   input  logic [NVW-1:0]               nv,
   input  logic [DW-1:0]                dim,
   output lsvm_pkg::dp_cmd_type         cmd,
   input  lsvm_pkg::dp_status_type      status,
   output logic [VIW-1:0]               idx,
   output logic [PW-1:0]                pos
);

   import lsvm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE        = 6'b000001,
      ST_MAC         = 6'b000010,
      ST_MAC_DRAIN   = 6'b000100,
      ST_SCORE       = 6'b001000,
      ST_SCORE_DRAIN = 6'b010000,
      ST_OUTPUT      = 6'b100000
   } state_type;

   state_type      state_ff, state_in;
   logic [VIW-1:0] idx_ff, idx_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [NVW-1:0] fill_ff, fill_in;
   logic           accept;
   logic           last;
   logic           more;
   logic [NVW-1:0] fill_max;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign last      = (NVW'(idx_ff) + NVW'(1)) == nv;
   assign more      = (DW'(pos_ff) + DW'(1)) < dim;
   assign fill_max  = (nv > fill_ff) ? nv : fill_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      fill_in  = fill_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_LOAD_VECTOR: begin
                     cmd.load_vector = 1'b1;
                  end
                  CMD_LOAD_WEIGHT: begin
                     cmd.load_weight = 1'b1;
                  end
                  CMD_QUERY: begin
                     cmd.query_start = 1'b1;
                     idx_in          = '0;
                     state_in        = (nv == '0) ? ST_MAC_DRAIN : ST_MAC;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            cmd.live      = NVW'(idx_ff) < fill_ff;
            idx_in        = idx_ff + VIW'(1);
            if (last) begin
               state_in = ST_MAC_DRAIN;
            end
         end
         ST_MAC_DRAIN: begin
            if (!status.busy) begin
               fill_in = fill_max;
               if (more) begin
                  pos_in   = pos_ff + PW'(1);
                  state_in = ST_IDLE;
               end else begin
                  cmd.acc_init = 1'b1;
                  idx_in       = '0;
                  state_in     = (nv == '0) ? ST_SCORE_DRAIN : ST_SCORE;
               end
            end
         end
         ST_SCORE: begin
            cmd.score_issue = 1'b1;
            cmd.live        = NVW'(idx_ff) < fill_ff;
            idx_in          = idx_ff + VIW'(1);
            if (last) begin
               state_in = ST_SCORE_DRAIN;
            end
         end
         ST_SCORE_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               pos_in       = '0;
               fill_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         pos_ff   <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         fill_ff  <= fill_in;
      end
   end

   assign idx = idx_ff;
   assign pos = pos_ff;

`ifndef NO_ASSERTIONS
   a_ready_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.busy)
      else $error("item taken while pipe still busy");

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result register overwritten");

   a_acc_init_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_init |-> !status.busy)
      else $error("accumulator cleared with terms in flight");

   a_ready_after_out: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> req_ready)
      else $error("not ready after result hand-off");

   a_query_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.query_start |-> (req_valid && req_ready))
      else $error("query started without an accepted item");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear-kernel SVM scorer. Fills the vector and
// weight stores, runs a few directed corner cases, then randomised batches of
// loads and queries under a range of register settings and handshake stalls.
// Every score is checked against a fixed-point predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb;
   import lsvm_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int N_VEC         = DEF_MAX_VECTORS;
   localparam int N_DIM         = DEF_MAX_DIM;
   localparam int SETTLE_CYCLES = 200;
   localparam int FILL_DIM      = 4;
   localparam int FILL_WIDE_VEC = 8;
   localparam int FILL_WIDE_DIM = 8;
   localparam int FILL_FULL_VEC = 2;
   localparam longint DOT_HI    = 64'sd549755813887;
   localparam longint DOT_LO    = -64'sd549755813888;
   localparam longint SCORE_HI  = 64'sd140737488355327;
   localparam longint SCORE_LO  = -64'sd140737488355328;

   typedef enum int {IDLE_SLOW_RX, IDLE_SLOW_TX, IDLE_NONE} idle_mode_type;

   typedef struct {
      logic [CMD_W-1:0]         command;
      logic [INDEX_W-1:0]       vector_index;
      logic [INDEX_W-1:0]       element_index;
      logic signed [DATA_W-1:0] value;
      logic [ALPHA_W-1:0]       alpha;
      logic                     label_negative;
   } svm_item_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      saturated;
   } svm_result_type;

   class score_predictor_type;
      logic signed [DATA_W-1:0] vec_mem [N_VEC*N_DIM];
      logic [ALPHA_W-1:0]       alpha_mem [N_VEC];
      logic                     label_mem [N_VEC];
      longint                   dot_acc [N_VEC];
      int unsigned              position;
      logic signed [BIAS_W-1:0] bias;
      logic [COUNT_W-1:0]       num_vec;
      logic [COUNT_W-1:0]       dim;
      svm_result_type           expected_q [$];
      int unsigned              mismatches;

      function new();
         bias       = '0;
         num_vec    = '0;
         dim        = FEATURE_DIM_RESET;
         position   = 0;
         mismatches = 0;
         foreach (dot_acc[n]) dot_acc[n] = 0;
      endfunction

      function int unsigned eff_vectors();
         return (num_vec > N_VEC) ? N_VEC : num_vec;
      endfunction

      function int unsigned eff_dim();
         if (dim == 0) return 1;
         return (dim > N_DIM) ? N_DIM : dim;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_BIAS:        bias = data;
            REG_NUM_VECTORS: num_vec = data[COUNT_W-1:0];
            REG_FEATURE_DIM: dim = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_item(svm_item_type it);
         longint         t;
         longint         sum;
         svm_result_type res;
         int unsigned    nv;
         int unsigned    pos;
         int             n;
         case (it.command)
            CMD_LOAD_VECTOR: vec_mem[{it.vector_index, it.element_index}] = it.value;
            CMD_LOAD_WEIGHT: begin
               alpha_mem[it.vector_index] = it.alpha;
               label_mem[it.vector_index] = it.label_negative;
            end
            CMD_QUERY: begin
               nv  = eff_vectors();
               pos = position;
               if (pos < N_DIM) begin
                  for (n = 0; n < nv; n++) begin
                     t = dot_acc[n] + longint'(vec_mem[n*N_DIM + pos]) * longint'(it.value);
                     if (t > DOT_HI) t = DOT_HI;
                     else if (t < DOT_LO) t = DOT_LO;
                     dot_acc[n] = t;
                  end
               end
               if (pos + 1 < eff_dim()) begin
                  position = pos + 1;
               end else begin
                  sum = longint'(bias);
                  for (n = 0; n < nv; n++) begin
                     // q.36 product back to q.24, rounding down
                     t = (dot_acc[n] * longint'(alpha_mem[n])) >>> 12;
                     if (label_mem[n]) sum -= t;
                     else sum += t;
                  end
                  res.saturated = 1'b0;
                  if (sum > SCORE_HI) begin
                     sum = SCORE_HI;
                     res.saturated = 1'b1;
                  end else if (sum < SCORE_LO) begin
                     sum = SCORE_LO;
                     res.saturated = 1'b1;
                  end
                  res.score = SCORE_W'(sum);
                  expected_q.insert(expected_q.size(), res);
                  foreach (dot_acc[k]) dot_acc[k] = 0;
                  position = 0;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_score(logic signed [SCORE_W-1:0] score, logic sat);
         svm_result_type want;
         if (expected_q.size() == 0) begin
            $error("score item with none expected: score %0d saturated %0b", score, sat);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         if (score !== want.score) begin
            $error("score: expected %0d, actual %0d", want.score, score);
            mismatches++;
         end
         if (sat !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, sat);
            mismatches++;
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [CMD_W-1:0]            req_command;
   logic [INDEX_W-1:0]          req_vector_index;
   logic [INDEX_W-1:0]          req_element_index;
   logic signed [DATA_W-1:0]    req_value;
   logic [ALPHA_W-1:0]          req_alpha;
   logic                        req_label_negative;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [SCORE_W-1:0]   rsp_score;
   logic                        rsp_saturated;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [CSR_ADDR_W-1:0]       paddr;
   logic [CSR_DATA_W-1:0]       pwdata;
   logic [CSR_DATA_W-1:0]       prdata;
   logic                        pready;

   score_predictor_type pred;
   int sender_idle_pct   = 19;
   int receiver_idle_pct = 73;
   int rx_hold_request   = 0;

   linear_svm_predict dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_vector_index   (req_vector_index),
      .req_element_index  (req_element_index),
      .req_value          (req_value),
      .req_alpha          (req_alpha),
      .req_label_negative (req_label_negative),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_score          (rsp_score),
      .rsp_saturated      (rsp_saturated),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_SLOW_RX: begin
            sender_idle_pct   = 19;
            receiver_idle_pct = 73;
         end
         IDLE_SLOW_TX: begin
            sender_idle_pct   = 73;
            receiver_idle_pct = 19;
         end
         default: begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
      endcase
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic svm_item_type random_item(input logic [CMD_W-1:0] cmd);
      svm_item_type it;
      it.command        = cmd;
      it.vector_index   = INDEX_W'($urandom);
      it.element_index  = INDEX_W'($urandom);
      it.value          = pick_value();
      it.alpha          = ($urandom_range(0, 7) == 0) ? '1 : ALPHA_W'($urandom);
      it.label_negative = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic send_item(input svm_item_type it);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= it.command;
      req_vector_index   <= it.vector_index;
      req_element_index  <= it.element_index;
      req_value          <= it.value;
      req_alpha          <= it.alpha;
      req_label_negative <= it.label_negative;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred.note_item(it);
   endtask

   task automatic send_query_run(input int unsigned count);
      repeat (count) send_item(random_item(CMD_QUERY));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pred.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      pred.set_reg(idx, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic score_batch(input logic signed [BIAS_W-1:0] bias_val, input int nv,
                              input int dim, input int n_items);
      int sent;
      int run;
      int r;
      wait_drained();
      write_csr(REG_BIAS, bias_val);
      write_csr(REG_NUM_VECTORS, nv);
      write_csr(REG_FEATURE_DIM, dim);
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            run = pred.eff_dim();
            // now and then a query cut short, finished by the next run
            if ($urandom_range(0, 9) == 0) run = $urandom_range(1, run);
            send_query_run(run);
            sent += run;
         end else if (r < 82) begin
            send_item(random_item(CMD_LOAD_VECTOR));
            sent++;
         end else if (r < 92) begin
            send_item(random_item(CMD_LOAD_WEIGHT));
            sent++;
         end else begin
            send_item(random_item(CMD_UNUSED));
            sent++;
         end
      end
      // finish a query left part way so the next settings start afresh
      if (pred.position != 0) send_query_run(pred.eff_dim() - pred.position);
   endtask

   initial begin
      int hold_left;
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready)
            pred.check_score(rsp_score, rsp_saturated);
         if (rx_hold_request > 0) begin
            hold_left = rx_hold_request;
            rx_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      svm_item_type it;
      int v;
      int e;
      int p;
      pred               = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_command        = '0;
      req_vector_index   = '0;
      req_element_index  = '0;
      req_value          = '0;
      req_alpha          = '0;
      req_label_negative = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      set_idle_mode(IDLE_SLOW_RX);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // write every store entry that a later query reads
      for (v = 0; v < N_VEC; v++) begin
         for (e = 0; e < N_DIM; e++) begin
            if (e < FILL_DIM || v < FILL_FULL_VEC
                || (v < FILL_WIDE_VEC && e < FILL_WIDE_DIM)) begin
               it = random_item(CMD_LOAD_VECTOR);
               it.vector_index  = INDEX_W'(v);
               it.element_index = INDEX_W'(e);
               send_item(it);
            end
         end
         it = random_item(CMD_LOAD_WEIGHT);
         it.vector_index = INDEX_W'(v);
         send_item(it);
      end

      // no vectors in use: score is the bias alone
      send_item(random_item(CMD_QUERY));
      wait_drained();
      write_csr(REG_BIAS, 32'sh7fffffff);
      send_item(random_item(CMD_QUERY));
      wait_drained();
      write_csr(REG_BIAS, 32'sh80000000);
      send_item(random_item(CMD_QUERY));

      it = random_item(CMD_LOAD_VECTOR);
      it.vector_index  = '1;
      it.element_index = '1;
      it.value         = 16'sh8000;
      send_item(it);
      it.vector_index  = '0;
      it.element_index = '0;
      it.value         = 16'sh7fff;
      send_item(it);
      it = random_item(CMD_LOAD_WEIGHT);
      it.vector_index   = '1;
      it.alpha          = '1;
      it.label_negative = 1'b1;
      send_item(it);
      it.vector_index   = '0;
      it.label_negative = 1'b0;
      send_item(it);
      // unused command, all fields high, must be ignored
      it = random_item(CMD_UNUSED);
      it.vector_index   = '1;
      it.element_index  = '1;
      it.value          = '1;
      it.alpha          = '1;
      it.label_negative = 1'b1;
      send_item(it);

      // vector count beyond the store and a zero dimension
      wait_drained();
      write_csr(REG_NUM_VECTORS, 127);
      write_csr(REG_FEATURE_DIM, 0);
      it = random_item(CMD_QUERY);
      it.value = 16'sh8000;
      send_item(it);
      it.value = 16'sh7fff;
      send_item(it);

      // dimension lowered part way through a query
      wait_drained();
      write_csr(REG_FEATURE_DIM, 4);
      send_query_run(3);
      wait_drained();
      write_csr(REG_FEATURE_DIM, 2);
      send_query_run(1);

      // long receiver stall with the sender still offering items
      wait_drained();
      write_csr(REG_NUM_VECTORS, 2);
      write_csr(REG_FEATURE_DIM, 1);
      rx_hold_request = 600;
      send_query_run(60);
      wait_drained();

      for (p = 0; p < 12; p++) begin
         set_idle_mode(idle_mode_type'(p / 4));
         case (p)
            0: score_batch(32'sh7fffffff, 64, 2, 105);
            1: score_batch(32'sh80000000, 127, 0, 105);
            2: score_batch($urandom, 0, 3, 105);
            3: score_batch($urandom, 1, 64, 105);
            4: score_batch($urandom, 2, 127, 105);
            default: score_batch($urandom, $urandom_range(0, 8), $urandom_range(1, 6), 105);
         endcase
      end

      wait_drained();
      if (pred.mismatches == 0 && pred.expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
